### rtl/ptwa_pkg.sv
// Package for the popularity table with aging: payload structs, commands, states, constants, aging function.
// No dependencies.
`timescale 1ns / 1ps
package ptwa_pkg;

  localparam int TableEntriesDef = 128;
  localparam int KeyBitsDef = 32;
  localparam int CountBits = 32;
  localparam int OccBits = 8;
  localparam logic [CountBits-1:0] UseStep = 32'd100;
  localparam logic [CountBits-1:0] KeepMin = 32'd31;
  localparam logic [CountBits-1:0] CountMax = 32'hFFFF_FFFF;
  localparam logic [OccBits-1:0] CapacityReset = 8'd100;

  typedef enum logic [1:0] {
    CMD_USE    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_INSERT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic        was_present;
    logic [31:0] key_count;
    logic [7:0]  occupancy;
    logic        swept;
  } out_item_t;

  // Per-cell operations issued by the controller.
  typedef struct packed {
    logic bump;    // add the use step to the matching cell
    logic remove;  // invalidate the matching cell
    logic clear;   // invalidate every cell
    logic age;     // aging sweep
    logic insert;  // write the key into the first free cell
  } cell_ctl_t;

  // floor(c*7/10) = 7*floor(c/10) + floor(7*(c mod 10)/10). The quotient by ten
  // comes from a reciprocal multiply, and c mod 10 only needs the low four bits.
  function automatic logic [CountBits-1:0] age_count(input logic [CountBits-1:0] c);
    logic [63:0] p;
    logic [28:0] tens;
    logic [3:0]  units;
    logic [2:0]  frac;
    p = {32'b0, c} * 64'h0000_0000_CCCC_CCCD;
    tens = p[63:35];
    units = c[3:0] - {tens[2:0], 1'b0} - {tens[0], 3'b0};
    unique case (units)
      4'd0, 4'd1: frac = 3'd0;
      4'd2:       frac = 3'd1;
      4'd3, 4'd4: frac = 3'd2;
      4'd5:       frac = 3'd3;
      4'd6, 4'd7: frac = 3'd4;
      4'd8:       frac = 3'd5;
      4'd9:       frac = 3'd6;
      default:    frac = 3'd0;
    endcase
    age_count = {tens, 3'b0} - {3'b0, tens} + {29'b0, frac};
  endfunction

endpackage

### rtl/ptwa_cell.sv
// One table cell: key, count, valid. Passes a "free cell seen" token to its neighbor.
// Depends on ptwa_pkg.
`timescale 1ns / 1ps
module ptwa_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ptwa_pkg::cell_ctl_t      ctl,
  input  logic [KEY_BITS-1:0]      key,
  input  logic                     free_in,
  output logic                     free_out,
  output logic                     hit,
  output logic [31:0]              count,
  output logic                     valid
);
  import ptwa_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic [31:0] count_r, count_nxt;
  logic valid_r, valid_nxt;
  logic [31:0] aged;

  assign hit = valid_r && (key_r == key);
  assign count = count_r;
  assign valid = valid_r;
  // Token is high once any cell at or below this one is free.
  assign free_out = free_in || !valid_r;
  assign aged = age_count(count_r);

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.remove && hit) begin
      valid_nxt = 1'b0;
    end else if (ctl.bump && hit) begin
      count_nxt = (count_r > CountMax - UseStep) ? CountMax : count_r + UseStep;
    end else if (ctl.age && valid_r) begin
      if (count_r >= KeepMin) count_nxt = aged;
      else valid_nxt = 1'b0;
    end else if (ctl.insert && !valid_r && !free_in) begin
      valid_nxt = 1'b1;
      count_nxt = UseStep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    count_r <= count_nxt;
    if (ctl.insert && !valid_r && !free_in) key_r <= key;
  end

endmodule

### rtl/popularity_table_with_aging.sv
// Popularity table with aging: one cell per entry, every cell matches the key,
// bumps, removes, ages or clears in the same cycle. An input beat is taken in the
// idle state only; a look-up state follows in which the cells also apply the
// command, then an output state that loads the result register once it is free or
// being read, and then idle again. A miss that sweeps adds an insert state, since
// the new key goes into the first free cell only after the sweep. The result waits
// in an output register; the next beat is taken while it waits, and its own result
// is held back until the register has been read.
// Depends on ptwa_pkg and ptwa_cell.
`timescale 1ns / 1ps
module popularity_table_with_aging #(
  parameter int TABLE_ENTRIES = ptwa_pkg::TableEntriesDef,
  parameter int KEY_BITS = ptwa_pkg::KeyBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptwa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptwa_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import ptwa_pkg::*;

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  state_t state_r, state_nxt;
  in_item_t item_r;
  out_item_t res_r;
  logic out_valid_r;
  logic out_load;
  logic [7:0] limit_r;
  logic present_r, swept_r;
  logic [31:0] count_hit_r;
  cell_ctl_t ctl;

  logic [TABLE_ENTRIES:0] free_chain;
  logic [TABLE_ENTRIES-1:0] hit_v, valid_v;
  logic [31:0] cnt_v [TABLE_ENTRIES];
  logic [KEY_BITS-1:0] cell_key;
  logic any_hit;
  logic [31:0] hit_count;
  logic [CntW-1:0] occ;
  logic [CntW:0] lim_eff;
  logic full_at_limit;

  assign cell_key = KEY_BITS'(item_r.key);
  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ptwa_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk, .rst_n, .ctl, .key(cell_key),
      .free_in(free_chain[g]), .free_out(free_chain[g+1]),
      .hit(hit_v[g]), .count(cnt_v[g]), .valid(valid_v[g])
    );
  end

  always_comb begin
    any_hit = |hit_v;
    hit_count = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_v[i]) hit_count = cnt_v[i];
    end
    occ = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      occ = occ + CntW'(valid_v[i]);
    end
  end

  always_comb begin
    lim_eff = (32'(limit_r) > TABLE_ENTRIES) ? (CntW+1)'(TABLE_ENTRIES)
                                             : (CntW+1)'(limit_r);
    full_at_limit = (CntW+1)'(occ) >= lim_eff;
  end

  assign in_stall = (state_r != ST_IDLE);
  // A finished result moves into the output register once that register is free.
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && !in_stall) state_nxt = ST_LOOK;
      ST_LOOK:   state_nxt = (item_r.command == CMD_USE && !any_hit && full_at_limit)
                             ? ST_INSERT : ST_OUT;
      ST_INSERT: state_nxt = ST_OUT;
      ST_OUT:    state_nxt = out_load ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Cell controls.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_LOOK: begin
        ctl.clear  = item_r.command == CMD_CLEAR;
        ctl.remove = item_r.command == CMD_REMOVE;
        ctl.bump   = item_r.command == CMD_USE;
        ctl.age    = item_r.command == CMD_USE && !any_hit && full_at_limit;
        ctl.insert = item_r.command == CMD_USE && !any_hit && !full_at_limit;
      end
      ST_INSERT: ctl.insert = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      limit_r <= CapacityReset;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
    if (in_valid && !in_stall) item_r <= in_data;
    if (state_r == ST_LOOK) begin
      present_r <= any_hit;
      swept_r <= ctl.age;
      count_hit_r <= hit_count;
    end
    if (out_load) begin
      res_r.was_present <= present_r;
      res_r.swept <= swept_r;
      res_r.occupancy <= (32'(occ) > 255) ? 8'd255 : 8'(occ);
      unique case (cmd_t'(item_r.command))
        CMD_USE:    res_r.key_count <= any_hit ? hit_count : 32'd0;
        CMD_NOP:    res_r.key_count <= present_r ? count_hit_r : 32'd0;
        default:    res_r.key_count <= 32'd0;
      endcase
    end
  end

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> out_valid) else $error("result not raised");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_one_hot_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_v)) else $error("duplicate key in table");

endmodule

### dv/testbench.sv
// Self-checking testbench for popularity_table_with_aging: directed and random
// use/remove/nop/clear traffic checked against a behavioral table model.
// Depends on ptwa_pkg and the popularity_table_with_aging RTL.
`timescale 1ns / 1ps
module testbench;
  import ptwa_pkg::*;

  localparam int Entries = 128;
  localparam int LimitCycles = 400000;

  class table_scoreboard;
    logic [31:0] keys[Entries];
    logic [31:0] counts[Entries];
    bit          valid[Entries];
    int          capacity;
    out_item_t   pending[$];
    int          errors;

    function new();
      capacity = 100;
      errors = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function int occupancy_now();
      int n;
      n = 0;
      foreach (valid[i]) if (valid[i]) n++;
      return n;
    endfunction

    // Works out the result of one accepted input beat and updates the table.
    function void note_input(in_item_t it);
      int pos;
      int limit;
      bit hit;
      bit did_sweep;
      logic [31:0] cnt;
      out_item_t res;
      pos = -1;
      did_sweep = 0;
      for (int i = 0; i < Entries; i++)
        if (pos < 0 && valid[i] && keys[i] == it.key) pos = i;
      hit = pos >= 0;
      cnt = hit ? counts[pos] : 32'd0;
      case (cmd_t'(it.command))
        CMD_USE: begin
          if (hit) begin
            cnt = (counts[pos] > CountMax - UseStep) ? CountMax : counts[pos] + UseStep;
            counts[pos] = cnt;
          end else begin
            limit = (capacity > Entries) ? Entries : capacity;
            if (occupancy_now() >= limit) begin
              did_sweep = 1;
              foreach (valid[i]) begin
                if (valid[i]) begin
                  if (counts[i] >= KeepMin)
                    counts[i] = 32'((64'(counts[i]) * 7) / 10);
                  else
                    valid[i] = 0;
                end
              end
            end
            cnt = 0;
            for (int i = 0; i < Entries; i++) begin
              if (!valid[i] && cnt == 0) begin
                valid[i] = 1;
                keys[i] = it.key;
                counts[i] = UseStep;
                cnt = UseStep;
              end
            end
          end
        end
        CMD_REMOVE: begin
          if (hit) valid[pos] = 0;
          cnt = 0;
        end
        CMD_CLEAR: begin
          foreach (valid[i]) valid[i] = 0;
          cnt = 0;
        end
        default: ;
      endcase
      res.was_present = hit;
      res.key_count = cnt;
      res.occupancy = 8'(occupancy_now());
      res.swept = did_sweep;
      pending = {pending, res};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.was_present !== exp_r.was_present) begin
        $error("was_present: expected %0d, got %0d", exp_r.was_present, got.was_present);
        errors++;
      end
      if (got.key_count !== exp_r.key_count) begin
        $error("key_count: expected %0d, got %0d", exp_r.key_count, got.key_count);
        errors++;
      end
      if (got.occupancy !== exp_r.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp_r.occupancy, got.occupancy);
        errors++;
      end
      if (got.swept !== exp_r.swept) begin
        $error("swept: expected %0d, got %0d", exp_r.swept, got.swept);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 0;

  table_scoreboard board = new();
  bit   hold_off = 0;
  bit   offering = 0;
  int   cycle_count = 0;
  logic [31:0] key_pool[16];

  always #1 clk = ~clk;

  popularity_table_with_aging u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Check each result beat at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // Receiver stall pattern: phases of no stall, light and heavy stalling,
  // plus a long hold-off when requested.
  always @(posedge clk) begin
    int phase;
    phase = (cycle_count / 300) % 3;
    if (hold_off) out_stall <= 1;
    else if (phase == 0) out_stall <= 0;
    else if (phase == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 2) != 0);
  end

  // Drives one input beat and waits until it is accepted. Valid stays high so
  // that a following beat can go out at the same edge.
  task automatic send_item(cmd_t c, logic [31:0] k);
    in_item_t it;
    it.command = c;
    it.key = k;
    offering = 1;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
  endtask

  // Drops valid after the last accepted beat of a burst.
  task automatic idle_input();
    if (offering) begin
      in_valid <= 0;
      offering = 0;
    end
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(1, 4);
    idle_input();
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [7:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.capacity = v;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 15)];
    return $urandom();
  endfunction

  task automatic random_phase(int n, int pool_span);
    int left;
    int burst;
    cmd_t c;
    int r;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        r = $urandom_range(0, 99);
        c = (r < 85) ? CMD_USE : (r < 95) ? CMD_REMOVE : (r < 98) ? CMD_NOP : CMD_CLEAR;
        if (pool_span > 0 && $urandom_range(0, 1)) send_item(c, $urandom_range(0, pool_span));
        else send_item(c, pick_key());
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) == 0) gap();
    end
    idle_input();
  endtask

  initial begin
    logic [7:0] limits[6];
    limits = '{8'd1, 8'd128, 8'd255, 8'd0, 8'd5, 8'd100};
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: key extremes, every command and the default limit.
    send_item(CMD_USE, 32'h0);
    send_item(CMD_USE, 32'hFFFF_FFFF);
    send_item(CMD_USE, 32'hFFFF_FFFF);
    send_item(CMD_NOP, 32'hFFFF_FFFF);
    send_item(CMD_NOP, 32'h1234_5678);
    send_item(CMD_REMOVE, 32'h0);
    send_item(CMD_REMOVE, 32'h0);
    send_item(CMD_CLEAR, 32'hA5A5_A5A5);
    send_item(CMD_USE, 32'h5A5A_5A5A);
    send_item(CMD_CLEAR, 32'h0);
    drain();

    // Limit of one: every miss but the first sweeps; a hot key survives aging.
    write_capacity(8'd1);
    repeat (4) send_item(CMD_USE, 32'd7);
    send_item(CMD_USE, 32'd8);
    send_item(CMD_USE, 32'd9);
    send_item(CMD_USE, 32'd7);
    send_item(CMD_CLEAR, 32'd0);
    drain();

    // Full table above the limit: sweeps that remove nothing repeat.
    write_capacity(8'd128);
    for (int i = 0; i < 128; i++) send_item(CMD_USE, 32'(i));
    drain();
    write_capacity(8'd2);
    send_item(CMD_USE, 32'd1000);
    send_item(CMD_USE, 32'd1001);
    drain();

    // Long receiver hold-off while beats keep being offered.
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20, 0);
    join
    drain();

    foreach (limits[i]) begin
      write_capacity(limits[i]);
      random_phase(300, (i % 2) ? 40 : 0);
      drain();
    end

    drain();
    if (board.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
